// ===== hdl/trtl_pkg.sv =====
// Shared types and constants for the timestamped record table lookup block.
// No dependencies; used by every module of the block.
package trtl_pkg;

    localparam int OPW     = 2;
    localparam int TIMEW   = 31;
    localparam int HINTW   = 11;
    localparam int RECW    = 10;
    localparam int SIGNW   = 3;
    localparam int WORDW   = 32;
    localparam int STATW   = 3;
    localparam int FOUNDW  = 11;
    localparam int CFGW    = 4;
    localparam int S_DATAW = 88;
    localparam int M_DATAW = 48;

    typedef enum logic [OPW-1:0] {
        OP_APPEND_TIME   = 2'd0,
        OP_APPEND_SIGNAL = 2'd1,
        OP_LOCATE        = 2'd2,
        OP_READ          = 2'd3
    } op_t;

    localparam logic [STATW-1:0] STAT_OK    = 3'd0;
    localparam logic [STATW-1:0] STAT_FULL  = 3'd1;
    localparam logic [STATW-1:0] STAT_ORDER = 3'd2;
    localparam logic [STATW-1:0] STAT_RANGE = 3'd3;
    localparam logic [STATW-1:0] STAT_HINT  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HINT0,
        S_HINT1,
        S_HINT2,
        S_SEARCH,
        S_READ,
        S_DONE
    } eng_state_t;

    // Classified request as it travels from the front queue to the engine.
    typedef struct packed {
        op_t              op;
        logic [TIMEW-1:0] time_value;
        logic             hint_none;
        logic [RECW-1:0]  hint_idx;
        logic [RECW-1:0]  record_number;
        logic [SIGNW-1:0] signal_number;
        logic [WORDW-1:0] signal_word;
    } cmd_t;

endpackage

// ===== hdl/trtl_front.sv =====
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on trtl_pkg.
module trtl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [trtl_pkg::S_DATAW-1:0]  s_tdata,
    input  logic [trtl_pkg::OPW-1:0]      s_tuser,
    output logic                          q_valid,
    output trtl_pkg::cmd_t                q_cmd,
    input  logic                          q_pop
);

    trtl_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    trtl_pkg::cmd_t in_cmd;
    logic           push;
    logic           pop;

    // Unpack and classify the incoming request.
    always_comb begin
        in_cmd.op            = trtl_pkg::op_t'(s_tuser);
        in_cmd.time_value    = s_tdata[30:0];
        in_cmd.hint_none     = s_tdata[41];
        in_cmd.hint_idx      = s_tdata[40:31];
        in_cmd.record_number = s_tdata[51:42];
        in_cmd.signal_number = s_tdata[54:52];
        in_cmd.signal_word   = s_tdata[86:55];
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== hdl/trtl_engine.sv =====
// Back end: table memories, hinted upper-bound search sequencer and result register.
// Depends on trtl_pkg.
module trtl_engine #(
    parameter int MAX_RECORDS = 1024,
    parameter int MAX_SIGNALS = 8
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        q_valid,
    input  trtl_pkg::cmd_t                              q_cmd,
    output logic                                        q_pop,
    input  logic [$clog2(MAX_SIGNALS+1)-1:0]            eff_spr,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [trtl_pkg::FOUNDW-1:0]                 m_found,
    output logic [trtl_pkg::WORDW-1:0]                  m_word,
    output logic [trtl_pkg::STATW-1:0]                  m_status
);

    localparam int RW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW  = $clog2(MAX_RECORDS + 1);
    localparam int SW  = $clog2(MAX_SIGNALS + 1);
    localparam int NW  = (SW > trtl_pkg::SIGNW) ? SW : trtl_pkg::SIGNW;
    localparam int AW  = (MAX_RECORDS * MAX_SIGNALS > 1) ?
                         $clog2(MAX_RECORDS * MAX_SIGNALS) : 1;
    localparam int XW  = ((CW > trtl_pkg::RECW) ? CW : trtl_pkg::RECW) + 1;
    localparam int SDEPTH = MAX_RECORDS * MAX_SIGNALS;

    // Table storage
    logic [trtl_pkg::TIMEW-1:0] time_mem [MAX_RECORDS];
    logic [trtl_pkg::WORDW-1:0] sig_mem  [SDEPTH];
    logic [SW-1:0]              fill_mem [MAX_RECORDS];

    trtl_pkg::eng_state_t       state_reg, state_next;
    trtl_pkg::cmd_t             cmd_reg, cmd_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [RW-1:0]              mid_reg, mid_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [SW-1:0]              filled_reg, filled_next;
    logic [trtl_pkg::TIMEW-1:0] last_time_reg, last_time_next;
    logic [trtl_pkg::FOUNDW-1:0] res_found_reg, res_found_next;
    logic [trtl_pkg::WORDW-1:0] res_word_reg, res_word_next;
    logic [trtl_pkg::STATW-1:0] res_status_reg, res_status_next;
    logic                       m_valid_reg, m_valid_next;
    logic [trtl_pkg::FOUNDW-1:0] m_found_reg;
    logic [trtl_pkg::WORDW-1:0] m_word_reg;
    logic [trtl_pkg::STATW-1:0] m_status_reg;
    logic                       out_load;

    logic [trtl_pkg::TIMEW-1:0] time_rdata_reg;
    logic [trtl_pkg::WORDW-1:0] sig_rdata_reg;
    logic [SW-1:0]              fill_rdata_reg;

    logic [RW-1:0]              time_raddr;
    logic [AW-1:0]              sig_raddr;
    logic [RW-1:0]              fill_raddr;
    logic                       time_we;
    logic [RW-1:0]              time_waddr;
    logic                       sig_we;
    logic [AW-1:0]              sig_waddr;
    logic                       fill_we;
    logic [RW-1:0]              fill_waddr;
    logic [SW-1:0]              fill_wdata;

    logic                       kick;
    logic [CW-1:0]              kick_lo;
    logic [CW-1:0]              kick_hi;
    logic [CW-1:0]              mid_w;
    logic [XW-1:0]              n_x;
    logic [XW-1:0]              qh_x;
    logic [XW-1:0]              ch_x;
    logic [XW-1:0]              qrec_x;

    function automatic logic [trtl_pkg::FOUNDW-1:0] to_found(input logic [CW-1:0] lo);
        logic signed [CW:0] v;
        v = $signed({1'b0, lo}) - $signed((CW+1)'(1));
        return trtl_pkg::FOUNDW'(v);
    endfunction

    assign n_x    = XW'(count_reg);
    assign qh_x   = XW'(q_cmd.hint_idx);
    assign ch_x   = XW'(cmd_reg.hint_idx);
    assign qrec_x = XW'(q_cmd.record_number);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        count_next      = count_reg;
        filled_next     = filled_reg;
        last_time_next  = last_time_reg;
        res_found_next  = res_found_reg;
        res_word_next   = res_word_reg;
        res_status_next = res_status_reg;
        q_pop           = 1'b0;
        time_we         = 1'b0;
        time_waddr      = RW'(count_reg);
        sig_we          = 1'b0;
        sig_waddr       = '0;
        fill_we         = 1'b0;
        fill_waddr      = RW'(count_reg);
        fill_wdata      = '0;
        time_raddr      = mid_reg;
        sig_raddr       = AW'(q_cmd.record_number) * AW'(MAX_SIGNALS)
                          + AW'(q_cmd.signal_number);
        fill_raddr      = RW'(q_cmd.record_number);
        kick            = 1'b0;
        kick_lo         = '0;
        kick_hi         = count_reg;
        mid_w           = '0;
        out_load        = 1'b0;

        case (state_reg)
            trtl_pkg::S_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    cmd_next        = q_cmd;
                    res_found_next  = '0;
                    res_word_next   = '0;
                    res_status_next = trtl_pkg::STAT_OK;
                    state_next      = trtl_pkg::S_DONE;
                    case (q_cmd.op)
                        trtl_pkg::OP_APPEND_TIME: begin
                            if (count_reg >= CW'(MAX_RECORDS)) begin
                                res_status_next = trtl_pkg::STAT_FULL;
                            end else if (q_cmd.time_value <= last_time_reg) begin
                                res_status_next = trtl_pkg::STAT_ORDER;
                            end else begin
                                // Open a record: its fill count starts at zero.
                                time_we        = 1'b1;
                                fill_we        = 1'b1;
                                fill_wdata     = '0;
                                count_next     = count_reg + CW'(1);
                                filled_next    = '0;
                                last_time_next = q_cmd.time_value;
                            end
                        end
                        trtl_pkg::OP_APPEND_SIGNAL: begin
                            if (count_reg == '0) begin
                                res_status_next = trtl_pkg::STAT_ORDER;
                            end else if (filled_reg >= eff_spr) begin
                                res_status_next = trtl_pkg::STAT_FULL;
                            end else begin
                                sig_we      = 1'b1;
                                sig_waddr   = AW'(RW'(count_reg - CW'(1))) * AW'(MAX_SIGNALS)
                                              + AW'(filled_reg);
                                fill_we     = 1'b1;
                                fill_waddr  = RW'(count_reg - CW'(1));
                                fill_wdata  = filled_reg + SW'(1);
                                filled_next = filled_reg + SW'(1);
                            end
                        end
                        trtl_pkg::OP_LOCATE: begin
                            if (q_cmd.hint_none) begin
                                kick = 1'b1;
                            end else if (qh_x >= n_x) begin
                                res_status_next = trtl_pkg::STAT_HINT;
                                kick            = 1'b1;
                            end else begin
                                time_raddr = RW'(q_cmd.hint_idx);
                                state_next = trtl_pkg::S_HINT0;
                            end
                        end
                        trtl_pkg::OP_READ: begin
                            if (qrec_x >= n_x ||
                                NW'(q_cmd.signal_number) >= NW'(eff_spr)) begin
                                res_status_next = trtl_pkg::STAT_RANGE;
                            end else begin
                                state_next = trtl_pkg::S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            trtl_pkg::S_HINT0: begin
                if (cmd_reg.time_value < time_rdata_reg) begin
                    res_status_next = trtl_pkg::STAT_HINT;
                    kick            = 1'b1;
                end else if (ch_x + XW'(1) == n_x) begin
                    res_found_next = trtl_pkg::FOUNDW'(cmd_reg.hint_idx);
                    state_next     = trtl_pkg::S_DONE;
                end else begin
                    time_raddr = RW'(ch_x + XW'(1));
                    state_next = trtl_pkg::S_HINT1;
                end
            end
            trtl_pkg::S_HINT1: begin
                if (cmd_reg.time_value < time_rdata_reg) begin
                    res_found_next = trtl_pkg::FOUNDW'(cmd_reg.hint_idx);
                    state_next     = trtl_pkg::S_DONE;
                end else if (ch_x + XW'(2) == n_x) begin
                    res_found_next = trtl_pkg::FOUNDW'(ch_x + XW'(1));
                    state_next     = trtl_pkg::S_DONE;
                end else begin
                    time_raddr = RW'(ch_x + XW'(2));
                    state_next = trtl_pkg::S_HINT2;
                end
            end
            trtl_pkg::S_HINT2: begin
                if (cmd_reg.time_value < time_rdata_reg) begin
                    res_found_next = trtl_pkg::FOUNDW'(ch_x + XW'(1));
                    state_next     = trtl_pkg::S_DONE;
                end else begin
                    kick    = 1'b1;
                    kick_lo = CW'(ch_x + XW'(2));
                end
            end
            trtl_pkg::S_SEARCH: begin
                kick = 1'b1;
                if (time_rdata_reg <= cmd_reg.time_value) begin
                    kick_lo = CW'(mid_reg) + CW'(1);
                    kick_hi = hi_reg;
                end else begin
                    kick_lo = lo_reg;
                    kick_hi = CW'(mid_reg);
                end
            end
            trtl_pkg::S_READ: begin
                // Slots past the record's fill count were never written: read zero.
                if (SW'(cmd_reg.signal_number) < fill_rdata_reg) begin
                    res_word_next = sig_rdata_reg;
                end else begin
                    res_word_next = '0;
                end
                state_next = trtl_pkg::S_DONE;
            end
            trtl_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = trtl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = trtl_pkg::S_IDLE;
            end
        endcase

        // Shared bisection step: probe the middle of [kick_lo, kick_hi) or finish.
        if (kick) begin
            if (kick_lo < kick_hi) begin
                mid_w      = kick_lo + ((kick_hi - kick_lo) >> 1);
                time_raddr = RW'(mid_w);
                mid_next   = RW'(mid_w);
                lo_next    = kick_lo;
                hi_next    = kick_hi;
                state_next = trtl_pkg::S_SEARCH;
            end else begin
                res_found_next = to_found(kick_lo);
                state_next     = trtl_pkg::S_DONE;
            end
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= trtl_pkg::S_IDLE;
            count_reg     <= '0;
            filled_reg    <= '0;
            last_time_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            filled_reg    <= filled_next;
            last_time_reg <= last_time_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_found_reg  <= res_found_next;
        res_word_reg   <= res_word_next;
        res_status_reg <= res_status_next;
        if (out_load) begin
            m_found_reg  <= res_found_reg;
            m_word_reg   <= res_word_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // Memories: one write and one registered read per array each cycle.
    always_ff @(posedge aclk) begin
        if (time_we) begin
            time_mem[time_waddr] <= cmd_next.time_value;
        end
        time_rdata_reg <= time_mem[time_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sig_we) begin
            sig_mem[sig_waddr] <= q_cmd.signal_word;
        end
        sig_rdata_reg <= sig_mem[sig_raddr];
    end

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_rdata_reg <= fill_mem[fill_raddr];
    end

    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;
    assign m_word   = m_word_reg;
    assign m_status = m_status_reg;

endmodule

// ===== hdl/timestamped_record_table_lookup.sv =====
// Top level of the timestamped record table lookup block.
// Depends on trtl_pkg, trtl_front and trtl_engine.
//
// Each request returns exactly one result, in request order. A locate makes
// up to three hint probes of the timestamp memory, then, if the hint does not
// settle it, one probe per bisection step, about log2(record count)+1 of them,
// and then hands off the result; a locate with no hint or a hint past the
// table goes straight to the bisection. Every probe is one registered read
// through the single read port of the timestamp memory. A two-entry queue
// sits between the request side and the engine, and a result register sits
// on the output, so requests keep flowing in while a result waits. The
// timestamp, signal and fill-count memories are not cleared at reset; the fill
// count of each record marks which signal slots hold data, and unfilled slots
// read as zero. No clearing pass is needed after reset.
module timestamped_record_table_lookup #(
    parameter int MAX_RECORDS = 1024,
    parameter int MAX_SIGNALS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: signals_per_record
    input  logic                          cfg_wr_en,
    input  logic [trtl_pkg::CFGW-1:0]     cfg_wr_data,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // time_value[30:0], hint_record[41:31], record_number[51:42],
    // signal_number[54:52], signal_word[86:55], zero pad[87]
    input  logic [trtl_pkg::S_DATAW-1:0]  s_tdata,
    // operation[1:0]
    input  logic [trtl_pkg::OPW-1:0]      s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found_record[10:0], read_word[42:11], zero pad[47:43]
    output logic [trtl_pkg::M_DATAW-1:0]  m_tdata,
    // status[2:0]
    output logic [trtl_pkg::STATW-1:0]    m_tuser
);

    localparam int SW = $clog2(MAX_SIGNALS + 1);

    logic [trtl_pkg::CFGW-1:0]   spr_reg;
    logic [SW-1:0]               eff_spr;
    logic                        q_valid;
    trtl_pkg::cmd_t              q_cmd;
    logic                        q_pop;
    logic [trtl_pkg::FOUNDW-1:0] out_found;
    logic [trtl_pkg::WORDW-1:0]  out_word;

    // Hold the signals-per-record setting; reset to one signal per record.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_reg <= trtl_pkg::CFGW'(1);
        end else if (cfg_wr_en) begin
            spr_reg <= cfg_wr_data;
        end
    end

    // Clamp the setting: zero acts as one, anything past the table width saturates.
    always_comb begin
        if (spr_reg == '0) begin
            eff_spr = SW'(1);
        end else if (32'(spr_reg) > MAX_SIGNALS) begin
            eff_spr = SW'(MAX_SIGNALS);
        end else begin
            eff_spr = SW'(spr_reg);
        end
    end

    trtl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    trtl_engine #(
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_SIGNALS (MAX_SIGNALS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .eff_spr  (eff_spr),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_found  (out_found),
        .m_word   (out_word),
        .m_status (m_tuser)
    );

    // Pack the result, found record in the low bits.
    assign m_tdata = {5'b0, out_word, out_found};

endmodule

// ===== hdl/trtl_checker.sv =====
// Port-level checks for timestamped_record_table_lookup, attached with bind.
// Depends on trtl_pkg.
module trtl_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [trtl_pkg::M_DATAW-1:0]  m_tdata,
    input logic [trtl_pkg::STATW-1:0]    m_tuser
);

    logic [2:0] pend_reg, pend_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Track requests in flight: queue, engine and result register.
    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc) begin
            pend_next = pend_reg + 3'd1;
        end else if (out_acc && !in_acc) begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 3'd0)
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd4)
        else $error("more requests in flight than buffering allows");

    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != trtl_pkg::STAT_OK |-> m_tdata[42:11] == 32'd0)
        else $error("failed request returned a signal word");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= trtl_pkg::STAT_HINT)
        else $error("undefined status code");

endmodule

bind timestamped_record_table_lookup trtl_checker u_trtl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/record_table_checker.sv =====
// Checker for the timestamped record table lookup block: keeps its own copy of
// the record table, predicts each result from the accepted requests and
// compares the results in order. Depends on trtl_pkg.
module record_table_checker #(
    parameter int MAX_RECORDS = 1024,
    parameter int MAX_SIGNALS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [trtl_pkg::CFGW-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [trtl_pkg::S_DATAW-1:0]  s_tdata,
    input  logic [trtl_pkg::OPW-1:0]      s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [trtl_pkg::M_DATAW-1:0]  m_tdata,
    input  logic [trtl_pkg::STATW-1:0]    m_tuser,
    output int                            fail_count,
    output int                            pending_count
);

    typedef struct packed {
        logic signed [trtl_pkg::FOUNDW-1:0] found;
        logic [trtl_pkg::WORDW-1:0]         word;
        logic [trtl_pkg::STATW-1:0]         status;
    } table_result_t;

    logic [trtl_pkg::TIMEW-1:0] time_mem [MAX_RECORDS];
    logic [trtl_pkg::WORDW-1:0] word_mem [MAX_RECORDS*MAX_SIGNALS];
    int                         rec_count;
    int                         fill_count;
    logic [trtl_pkg::CFGW-1:0]  spr_reg;
    table_result_t              expected_q [$];

    function automatic int active_signals();
        if (spr_reg == 0) return 1;
        if (spr_reg > MAX_SIGNALS) return MAX_SIGNALS;
        return int'(spr_reg);
    endfunction

    // Upper bound over [lo, rec_count): last record with timestamp <= t.
    function automatic int last_at_or_below(int lo, logic [trtl_pkg::TIMEW-1:0] t);
        int hi;
        int mid;
        hi = rec_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (time_mem[mid] <= t) lo = mid + 1;
            else hi = mid;
        end
        return lo - 1;
    endfunction

    function automatic table_result_t apply_request(trtl_pkg::op_t op,
                                                    logic [trtl_pkg::S_DATAW-1:0] data);
        logic [trtl_pkg::TIMEW-1:0]        t;
        logic signed [trtl_pkg::HINTW-1:0] hint;
        logic [trtl_pkg::RECW-1:0]         rec;
        logic [trtl_pkg::SIGNW-1:0]        sig;
        logic [trtl_pkg::WORDW-1:0]        word;
        logic [trtl_pkg::TIMEW-1:0]        last_t;
        table_result_t                     res;
        int                                n;
        int                                spr;
        int                                h;
        int                                found;
        t      = data[30:0];
        hint   = data[41:31];
        rec    = data[51:42];
        sig    = data[54:52];
        word   = data[86:55];
        n      = rec_count;
        spr    = active_signals();
        found  = 0;
        res.word   = '0;
        res.status = trtl_pkg::STAT_OK;
        case (op)
            trtl_pkg::OP_APPEND_TIME: begin
                last_t = (n > 0) ? time_mem[n-1] : '0;
                if (n >= MAX_RECORDS) begin
                    res.status = trtl_pkg::STAT_FULL;
                end else if (t <= last_t) begin
                    res.status = trtl_pkg::STAT_ORDER;
                end else begin
                    time_mem[n] = t;
                    for (int k = 0; k < MAX_SIGNALS; k++) word_mem[n*MAX_SIGNALS + k] = '0;
                    rec_count  = n + 1;
                    fill_count = 0;
                end
            end
            trtl_pkg::OP_APPEND_SIGNAL: begin
                if (n == 0) begin
                    res.status = trtl_pkg::STAT_ORDER;
                end else if (fill_count >= spr) begin
                    res.status = trtl_pkg::STAT_FULL;
                end else begin
                    word_mem[(n-1)*MAX_SIGNALS + fill_count] = word;
                    fill_count++;
                end
            end
            trtl_pkg::OP_LOCATE: begin
                if (hint < 0) begin
                    found = last_at_or_below(0, t);
                end else begin
                    h = hint;
                    if (h >= n || t < time_mem[h]) begin
                        res.status = trtl_pkg::STAT_HINT;
                        found = last_at_or_below(0, t);
                    end else if (h == n - 1 || t < time_mem[h+1]) begin
                        found = h;
                    end else if (h == n - 2 || t < time_mem[h+2]) begin
                        found = h + 1;
                    end else begin
                        found = last_at_or_below(h + 2, t);
                    end
                end
            end
            trtl_pkg::OP_READ: begin
                if (int'(rec) >= n || int'(sig) >= spr) res.status = trtl_pkg::STAT_RANGE;
                else res.word = word_mem[int'(rec)*MAX_SIGNALS + int'(sig)];
            end
            default: ;
        endcase
        res.found = trtl_pkg::FOUNDW'(found);
        return res;
    endfunction

    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (!aresetn) begin
            rec_count  = 0;
            fill_count = 0;
            spr_reg    = 4'd1;
            expected_q.delete();
        end else begin
            // results first: a request accepted at this edge cannot be answered yet
            if (m_tvalid && m_tready) begin
                got.found  = m_tdata[10:0];
                got.word   = m_tdata[42:11];
                got.status = m_tuser;
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.found !== want.found) begin
                        $error("found_record: expected %0d, got %0d",
                               $signed(want.found), $signed(got.found));
                        fail_count++;
                    end
                    if (got.word !== want.word) begin
                        $error("read_word: expected %08h, got %08h", want.word, got.word);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) spr_reg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                expected_q.insert(expected_q.size(),
                                  apply_request(trtl_pkg::op_t'(s_tuser), s_tdata));
            end
        end
        pending_count = expected_q.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the timestamped record table lookup block: makes requests,
// configuration writes and receiver stalls, and gives the verdict.
// Depends on trtl_pkg, record_table_checker and timestamped_record_table_lookup.
module tb;

    localparam int                                MAX_RECORDS = 1024;
    localparam int                                LONG_HOLD   = 80;
    localparam int                                PHASE_ITEMS = 380;
    localparam logic [trtl_pkg::TIMEW-1:0]        TIME_MAX    = '1;
    localparam logic signed [trtl_pkg::HINTW-1:0] NO_HINT     = '1;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [trtl_pkg::CFGW-1:0]     cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [trtl_pkg::S_DATAW-1:0]  s_tdata     = '0;
    logic [trtl_pkg::OPW-1:0]      s_tuser     = trtl_pkg::OP_APPEND_TIME;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [trtl_pkg::M_DATAW-1:0]  m_tdata;
    logic [trtl_pkg::STATW-1:0]    m_tuser;

    int fail_count;
    int pending_count;

    // Stimulus bookkeeping: timestamps the table should hold, so that locates
    // and reads can aim at real records. Shaping only, never checked.
    logic [trtl_pkg::TIMEW-1:0] table_times [$];
    int                         spr_now        = 1;
    bit                         idle_on        = 1'b1;
    int                         rx_hold_asked  = 0;
    int                         rx_hold_served = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    timestamped_record_table_lookup u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    record_table_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic logic [trtl_pkg::TIMEW-1:0] last_time();
        return (table_times.size() > 0) ? table_times[$] : '0;
    endfunction

    // Offer one request starting at a falling edge and hold it until it is
    // taken. Valid stays high on return so back-to-back requests leave no gap.
    task automatic send_request(input trtl_pkg::op_t op,
                                input logic [trtl_pkg::TIMEW-1:0] t,
                                input logic signed [trtl_pkg::HINTW-1:0] hint,
                                input logic [trtl_pkg::RECW-1:0] rec,
                                input logic [trtl_pkg::SIGNW-1:0] sig,
                                input logic [trtl_pkg::WORDW-1:0] word);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        // track what a successful timestamp append adds to the table
        if (op == trtl_pkg::OP_APPEND_TIME && table_times.size() < MAX_RECORDS &&
            t > last_time())
            table_times.insert(table_times.size(), t);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, word, sig, rec, hint, t};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every outstanding request has its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    // Write signals_per_record only while the block is idle.
    task automatic write_spr(input logic [trtl_pkg::CFGW-1:0] value);
        drain();
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        spr_now = (value == 0) ? 1 : (value > 8) ? 8 : int'(value);
    endtask

    // One random request. Most are well formed: increasing timestamps,
    // locates aimed near stored records with hints at, before or past them,
    // reads inside the table. The rest is stale timestamps and raw noise.
    task automatic random_request();
        trtl_pkg::op_t                     op;
        logic [trtl_pkg::TIMEW-1:0]        t;
        logic signed [trtl_pkg::HINTW-1:0] hint;
        logic [trtl_pkg::RECW-1:0]         rec;
        logic [trtl_pkg::SIGNW-1:0]        sig;
        logic [trtl_pkg::WORDW-1:0]        word;
        int                                n;
        int                                pick;
        int                                r;
        int                                k;
        int                                append_cut;
        longint                            room;
        longint                            step;
        n    = table_times.size();
        t    = trtl_pkg::TIMEW'($urandom);
        hint = trtl_pkg::HINTW'(int'($urandom_range(0, 1024)) - 1);
        rec  = trtl_pkg::RECW'($urandom);
        sig  = trtl_pkg::SIGNW'($urandom);
        word = $urandom;
        // push harder toward a full table in the closing phase
        append_cut = (!idle_on && n < MAX_RECORDS) ? 85 : 60;
        pick = $urandom_range(0, 99);
        if (pick < append_cut) begin
            op   = trtl_pkg::OP_APPEND_TIME;
            room = longint'(TIME_MAX) - longint'(last_time());
            if ($urandom_range(0, 15) == 0 || room == 0) begin
                // stale timestamp: equal to or just below the newest one
                step = longint'($urandom_range(0, 3));
                if (step > longint'(last_time())) step = longint'(last_time());
                t = trtl_pkg::TIMEW'(longint'(last_time()) - step);
            end else begin
                step = ($urandom_range(0, 7) == 0) ? longint'(1) :
                       longint'($urandom_range(1, 1 << 21));
                if (step > room) step = room;
                t = trtl_pkg::TIMEW'(longint'(last_time()) + step);
            end
        end else if (pick < 75) begin
            op = trtl_pkg::OP_APPEND_SIGNAL;
        end else if (pick < 90) begin
            op = trtl_pkg::OP_LOCATE;
            if (n > 0 && $urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, n - 1);
                t = trtl_pkg::TIMEW'(table_times[r] + (($urandom_range(0, 1) == 0) ? 0 :
                                                       $urandom_range(0, 1 << 20)));
                k = $urandom_range(0, 6);
                // hint on the record, a few before it, or one past it
                if (k == 6) begin
                    hint = (r + 1 < MAX_RECORDS) ? trtl_pkg::HINTW'(r + 1) :
                                                   trtl_pkg::HINTW'(r);
                end else begin
                    hint = (r - k < 0) ? NO_HINT : trtl_pkg::HINTW'(r - k);
                end
            end
        end else begin
            op = trtl_pkg::OP_READ;
            if (n > 0 && $urandom_range(0, 4) != 0) begin
                rec = trtl_pkg::RECW'($urandom_range(0, n - 1));
                sig = trtl_pkg::SIGNW'($urandom_range(0, spr_now - 1));
            end
        end
        send_request(op, t, hint, rec, sig, word);
    endtask

    // Receiver: random stall bursts, a long hold-off on request from the
    // stimulus, and always ready once idling is switched off.
    initial begin
        int burst;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_served != rx_hold_asked) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                rx_hold_served++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [trtl_pkg::CFGW-1:0] spr_plan [5];
        spr_plan = '{4'd8, 4'd3, 4'd1, 4'd12, 4'd6};

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register value zero acts as one slot per record.
        write_spr(4'd0);

        // Empty table: plain locate, locate with a hint past the end at the
        // largest query, read, signal before any record, zero timestamp.
        send_request(trtl_pkg::OP_LOCATE, '0, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, TIME_MAX, 11'sd1023, '0, '0, '0);
        send_request(trtl_pkg::OP_READ, '0, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_APPEND_SIGNAL, '0, NO_HINT, '0, '0, 32'hFFFF_FFFF);
        send_request(trtl_pkg::OP_APPEND_TIME, '0, NO_HINT, '0, '0, '0);

        // First record, one slot: fill it, overfill it, read in and out of
        // range, then repeated and decreasing timestamps.
        send_request(trtl_pkg::OP_APPEND_TIME, 31'd10, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_APPEND_SIGNAL, '0, NO_HINT, '0, '0, 32'hFFFF_FFFF);
        send_request(trtl_pkg::OP_APPEND_SIGNAL, '0, NO_HINT, '0, '0, 32'h1234_5678);
        send_request(trtl_pkg::OP_READ, '0, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_READ, '0, NO_HINT, '0, 3'd1, '0);
        send_request(trtl_pkg::OP_APPEND_TIME, 31'd10, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_APPEND_TIME, 31'd5, NO_HINT, '0, '0, '0);

        // Register above the slot count acts as the full eight slots.
        write_spr(4'd15);
        send_request(trtl_pkg::OP_APPEND_TIME, 31'd20, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_APPEND_SIGNAL, '0, NO_HINT, '0, '0, 32'h8000_0001);
        send_request(trtl_pkg::OP_READ, '0, NO_HINT, 10'd1, 3'd7, '0);
        send_request(trtl_pkg::OP_READ, '0, NO_HINT, 10'd1, 3'd0, '0);
        send_request(trtl_pkg::OP_READ, '0, NO_HINT, 10'd2, 3'd0, '0);

        // Hint hits on itself and on the next record, hint above the query,
        // hint past the table, no hint.
        send_request(trtl_pkg::OP_LOCATE, 31'd15, 11'sd0, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, 31'd25, 11'sd0, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, 31'd5, 11'sd1, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, 31'd30, 11'sd2, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, TIME_MAX, NO_HINT, '0, '0, '0);

        // Hint too far back: search continues past hint+2.
        send_request(trtl_pkg::OP_APPEND_TIME, 31'd30, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_APPEND_TIME, 31'd40, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, 31'd45, 11'sd0, '0, '0, '0);

        foreach (spr_plan[p]) begin
            if (p == 4) idle_on = 1'b0;
            write_spr(spr_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stall the receiver long enough to back up the input side
                if (p == 1 && i == 100) rx_hold_asked++;
                if (p == 2 && i == 150) drain();
                random_request();
            end
        end

        // Largest timestamp, then again once it (or a full table) blocks it.
        send_request(trtl_pkg::OP_APPEND_TIME, TIME_MAX, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_APPEND_TIME, TIME_MAX, NO_HINT, '0, '0, '0);
        send_request(trtl_pkg::OP_LOCATE, TIME_MAX, 11'sd1023, '0, '0, '0);

        drain();
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #(12 * 600000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/trtl_pkg.sv
hdl/trtl_front.sv
hdl/trtl_engine.sv
hdl/timestamped_record_table_lookup.sv
hdl/trtl_checker.sv
test/record_table_checker.sv
test/tb.sv
